### rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// shared constants, codes and cell-to-cell types of the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEFAULT_ENTRIES = 32;
  localparam int HANDLE_W        = 5;
  localparam int IVL_W           = 29;
  localparam int WORD_W          = 32;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_SCHEDULE = 2'd1,
    KIND_POLL     = 2'd2,
    KIND_CANCEL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_EXP  = 2'd2,
    ST_INACTIVE = 2'd3
  } status_t;

  localparam logic [0:0] REG_HUNDRED_US = 1'b0;

  // one active list slot as it travels along the chain
  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   expiry;
    logic [WORD_W-1:0]   ivl;
  } slot_t;

  // broadcast command to all cells for one operation
  typedef struct packed {
    logic                insert;
    logic                remove;
    slot_t               new_slot;
    logic [WORD_W-1:0]   now;
    logic [HANDLE_W-1:0] rm_handle;
    logic                rm_head;
  } cmd_t;

  // per-cell flags handed to the right neighbor
  typedef struct packed {
    logic ins_hit;   // insertion point is at or left of this cell
    logic rm_hit;    // removed slot is at or left of this cell
  } flags_t;

endpackage

### rtl/sorted_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// pool of one-shot timers kept in expiry order by a chain of list cells
// ----------------------------------------------------------------------------
// in_ beats carry a kind: tick, schedule, poll or cancel. a tick advances the
// 32-bit time counter and gives no out_ beat; every other kind gives one.
// a tick leaves in_ready high. when any other item is taken, all list cells
// compare and shift in parallel along the chain and the result is
// registered; out_valid rises the cycle after. the next beat is taken once
// the result has been handed to out_; an out_ stall holds the result and
// blocks in_ until taken.
// schedule pops the oldest free handle, stores its payload in the entry
// memory and inserts it into the chain at its ordered place. poll looks at
// the head cell only; an expired head is returned and its handle freed.
// cancel removes a handle wherever it sits in the chain.
// hundred_us_ticks lies at cfg address 0; it scales intervals by 10.
// reset empties the list, refills the free ring in order, zeroes time and
// sets hundred_us_ticks; entry payloads are undefined until scheduled.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
  import stq_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [WORD_W-1:0]        in_target,
  input  logic signed [WORD_W-1:0] in_message_code,
  input  logic signed [WORD_W-1:0] in_param_value,
  input  logic [IVL_W-1:0]         in_interval,
  input  logic [HANDLE_W-1:0]      in_handle,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [HANDLE_W-1:0]      out_handle_out,
  output logic [WORD_W-1:0]        out_fired_target,
  output logic signed [WORD_W-1:0] out_fired_message,
  output logic signed [WORD_W-1:0] out_fired_param,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [WORD_W-1:0]        pwdata,
  output logic [WORD_W-1:0]        prdata,
  output logic                     pready
);

  logic hundred_r;
  logic [WORD_W-1:0] now_r;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? {{(WORD_W-1){1'b0}}, hundred_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) hundred_r <= 1'b1;
    else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
      hundred_r <= pwdata[0];
  end

  // chain
  cmd_t   cmd;
  slot_t  slots [ENTRIES+1];
  slot_t  zero_slot;
  flags_t flg   [ENTRIES+1];
  assign zero_slot = '0;
  assign flg[0]    = '0;
  assign slots[ENTRIES] = zero_slot;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    stq_cell u_cell (
      .clk, .rst_n, .cmd,
      .left_slot  (g == 0 ? zero_slot : slots[(g == 0) ? 0 : g-1]),
      .left_flags (flg[g]),
      .right_slot (slots[g+1]),
      .slot       (slots[g]),
      .flags      (flg[g+1])
    );
  end

  // free ring
  logic                ring_empty, ring_pop, ring_push;
  logic [HANDLE_W-1:0] ring_head, ring_push_h;
  stq_free_ring #(.ENTRIES(ENTRIES)) u_ring (
    .clk, .rst_n, .pop(ring_pop), .push(ring_push), .push_handle(ring_push_h),
    .empty(ring_empty), .head_handle(ring_head)
  );

  // entry payload memory, read registered for poll
  logic [3*WORD_W-1:0] pay_mem [ENTRIES];
  logic [3*WORD_W-1:0] pay_rd_r;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // control
  typedef enum logic [1:0] {S_IDLE = 2'b01, S_OUT = 2'b10} state_t;
  state_t state_r;
  logic take;
  logic [WORD_W-1:0] ivl;
  logic [WORD_W-1:0] ivl10;
  logic head_exp, cancel_hit, full;
  logic [1:0] st_r;
  logic [HANDLE_W-1:0] ho_r;
  logic fire_r;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign ivl10     = {3'b000, in_interval} * WORD_W'(10);
  assign ivl       = hundred_r ? ivl10 : {3'b000, in_interval};
  assign head_exp  = slots[0].valid &&
                     ((slots[0].expiry - now_r) > slots[0].ivl);
  assign cancel_hit = flg[ENTRIES].rm_hit;
  assign full      = slots[ENTRIES-1].valid;

  always_comb begin
    cmd = '0;
    cmd.now = now_r;
    cmd.new_slot.valid  = 1'b1;
    cmd.new_slot.handle = ring_head;
    cmd.new_slot.ivl    = ivl;
    cmd.new_slot.expiry = ivl + now_r;
    cmd.rm_handle = in_handle;
    cmd.rm_head   = (kind_t'(in_kind) == KIND_POLL);
    if (take) begin
      case (kind_t'(in_kind))
        KIND_SCHEDULE: cmd.insert = !ring_empty && !full;
        KIND_POLL:     cmd.remove = head_exp;
        KIND_CANCEL:   cmd.remove = 1'b1;
        default:       cmd.insert = 1'b0;
      endcase
    end
  end

  assign ring_pop    = cmd.insert;
  assign ring_push   = take && ((kind_t'(in_kind) == KIND_POLL && head_exp) ||
                                (kind_t'(in_kind) == KIND_CANCEL && cancel_hit));
  assign ring_push_h = (kind_t'(in_kind) == KIND_POLL) ? slots[0].handle : in_handle;

  // payload of the head is captured with the beat and held through a stall
  always_ff @(posedge clk) begin
    if (cmd.insert)
      pay_mem[ring_head[AW-1:0]] <= {in_target, in_message_code, in_param_value};
    if (take)
      pay_rd_r <= pay_mem[slots[0].handle[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (take) begin
          if (kind_t'(in_kind) == KIND_TICK) now_r <= now_r + 1'b1;
          else state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fire_r <= 1'b0;
      ho_r   <= '0;
      case (kind_t'(in_kind))
        KIND_SCHEDULE: begin
          st_r <= cmd.insert ? ST_OK : ST_NO_FREE;
          if (cmd.insert) ho_r <= ring_head;
        end
        KIND_POLL: begin
          st_r <= head_exp ? ST_OK : ST_NOT_EXP;
          fire_r <= head_exp;
          if (head_exp) ho_r <= slots[0].handle;
        end
        KIND_CANCEL: begin
          st_r <= cancel_hit ? ST_OK : ST_INACTIVE;
          if (cancel_hit) ho_r <= in_handle;
        end
        default: st_r <= ST_OK;
      endcase
    end
  end

  assign out_valid         = (state_r == S_OUT);
  assign out_status        = st_r;
  assign out_handle_out    = ho_r;
  assign out_fired_target  = fire_r ? pay_rd_r[3*WORD_W-1:2*WORD_W] : '0;
  assign out_fired_message = fire_r ? pay_rd_r[2*WORD_W-1:WORD_W] : '0;
  assign out_fired_param   = fire_r ? pay_rd_r[WORD_W-1:0] : '0;

endmodule

### rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// one slot of the ordered active list; shifts right on insert, left on remove
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  slot_t  left_slot,
  input  flags_t left_flags,
  input  slot_t  right_slot,
  output slot_t  slot,
  output flags_t flags
);

  slot_t slot_r, slot_nxt;
  logic  unexpired, here_ins, here_rm;
  logic [WORD_W-1:0] rem;

  assign rem       = slot_r.expiry - cmd.now;
  assign unexpired = (rem <= slot_r.ivl);
  // first valid cell that is unexpired and outlasts the new entry, or first empty
  assign here_ins  = !slot_r.valid || (unexpired && (cmd.new_slot.ivl < rem));
  assign here_rm   = slot_r.valid &&
                     (cmd.rm_head ? 1'b1 : (slot_r.handle == cmd.rm_handle));
  assign flags.ins_hit = left_flags.ins_hit || here_ins;
  assign flags.rm_hit  = left_flags.rm_hit || here_rm;
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.insert) begin
      if (left_flags.ins_hit) slot_nxt = left_slot;
      else if (here_ins)      slot_nxt = cmd.new_slot;
    end else if (cmd.remove) begin
      if (left_flags.rm_hit || here_rm) slot_nxt = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.handle <= slot_nxt.handle;
    slot_r.expiry <= slot_nxt.expiry;
    slot_r.ivl    <= slot_nxt.ivl;
  end

endmodule

### rtl/stq_free_ring.sv
// ----------------------------------------------------------------------------
// stq_free_ring
// fifo of free handles, reset to all handles in ascending order
// ----------------------------------------------------------------------------
module stq_free_ring
  import stq_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop,
  input  logic                push,
  input  logic [HANDLE_W-1:0] push_handle,
  output logic                empty,
  output logic [HANDLE_W-1:0] head_handle
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // small ring with reset values, kept in flip-flops
  logic [HANDLE_W-1:0] ring_r [ENTRIES];
  logic [IW-1:0]       head_r, tail_r;
  logic [IW:0]         count_r;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
    return (p == IW'(ENTRIES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty       = (count_r == '0);
  assign head_handle = ring_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) ring_r[i] <= HANDLE_W'(i);
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= (IW+1)'(ENTRIES);
    end else begin
      if (pop) head_r <= inc(head_r);
      if (push && count_r != (IW+1)'(ENTRIES)) begin
        ring_r[tail_r] <= push_handle;
        tail_r <= inc(tail_r);
      end
      count_r <= count_r + (IW+1)'(push && count_r != (IW+1)'(ENTRIES)) -
                 (IW+1)'(pop);
    end
  end

endmodule

### bench/sorted_timer_queue_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_core_checker
// watches the in_, out_ and config channels of the timer queue, keeps its own
// copy of the timer pool, free ring and expiry-ordered list, and compares
// every out_ beat field by field with the oldest predicted result
// ----------------------------------------------------------------------------
module sorted_timer_queue_core_checker
  import stq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [31:0]       in_target,
  input  logic [31:0]       in_message_code,
  input  logic [31:0]       in_param_value,
  input  logic [IVL_W-1:0]  in_interval,
  input  logic [4:0]        in_handle,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [1:0]        out_status,
  input  logic [4:0]        out_handle_out,
  input  logic [31:0]       out_fired_target,
  input  logic [31:0]       out_fired_message,
  input  logic [31:0]       out_fired_param,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    status_t     status;
    logic [4:0]  handle;
    logic [31:0] target;
    logic [31:0] message;
    logic [31:0] param;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [31:0] now_q;
  logic [31:0] expiry_q [32];
  logic [31:0] span_q   [32];
  logic [31:0] target_q [32];
  logic [31:0] msg_q    [32];
  logic [31:0] param_q  [32];
  logic [4:0]  order_q  [32];
  logic [4:0]  ring_q   [32];
  int          active_n;
  int          free_n;
  logic [4:0]  free_head;
  logic        scale10;

  assign pending = expected_results.size();

  function automatic void release_handle(logic [4:0] h);
    if (free_n < 32) begin
      ring_q[5'(free_head + free_n)] = h;
      free_n++;
    end
  endfunction

  function automatic void unlink_at(int pos);
    for (int i = pos; i + 1 < active_n; i++) order_q[i] = order_q[i + 1];
    active_n--;
  endfunction

  function automatic void run_timer_item(logic [1:0] kind, logic [31:0] tgt,
      logic [31:0] msg, logic [31:0] prm, logic [IVL_W-1:0] ivl_in, logic [4:0] hin);
    timer_result_t r;
    logic [4:0]    h;
    logic [31:0]   span;
    logic [31:0]   rem;
    int            pos;
    r = '0;
    case (kind_t'(kind))
      KIND_TICK: begin
        now_q = now_q + 1;
        return;
      end
      KIND_SCHEDULE: begin
        if (free_n == 0 || active_n >= 32) begin
          r.status = ST_NO_FREE;
        end else begin
          h = ring_q[free_head];
          free_head = free_head + 1;
          free_n--;
          span = {3'b0, ivl_in};
          if (scale10) span = span * 32'd10;
          span_q[h]   = span;
          expiry_q[h] = span + now_q;
          target_q[h] = tgt;
          msg_q[h]    = msg;
          param_q[h]  = prm;
          pos = active_n;
          for (int i = 0; i < active_n; i++) begin
            rem = expiry_q[order_q[i]] - now_q;
            if (rem <= span_q[order_q[i]] && span < rem) begin
              pos = i;
              break;
            end
          end
          for (int i = active_n; i > pos; i--) order_q[i] = order_q[i - 1];
          order_q[pos] = h;
          active_n++;
          r.status = ST_OK;
          r.handle = h;
        end
      end
      KIND_POLL: begin
        r.status = ST_NOT_EXP;
        if (active_n > 0) begin
          h = order_q[0];
          // wrap-safe: remaining time beyond the span means it has passed
          if (expiry_q[h] - now_q > span_q[h]) begin
            r.status  = ST_OK;
            r.handle  = h;
            r.target  = target_q[h];
            r.message = msg_q[h];
            r.param   = param_q[h];
            unlink_at(0);
            release_handle(h);
          end
        end
      end
      default: begin
        r.status = ST_INACTIVE;
        for (int i = 0; i < active_n; i++) begin
          if (order_q[i] == hin) begin
            unlink_at(i);
            release_handle(hin);
            r.status = ST_OK;
            r.handle = hin;
            break;
          end
        end
      end
    endcase
    expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    timer_result_t exp_r;
    timer_result_t got_r;
    if (!rst_n) begin
      now_q     = '0;
      active_n  = 0;
      free_n    = 32;
      free_head = '0;
      scale10   = 1'b1;
      for (int i = 0; i < 32; i++) ring_q[i] = 5'(i);
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(4 * REG_HUNDRED_US))
        scale10 = pwdata[0];
      if (out_valid && out_ready) begin
        got_r = {status_t'(out_status), out_handle_out, out_fired_target,
                 out_fired_message, out_fired_param};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d handle %0d",
                     out_status, out_handle_out);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp st %0d h %0d t %h m %h p %h / got st %0d h %0d t %h m %h p %h",
                       exp_r.status, exp_r.handle, exp_r.target, exp_r.message,
                       exp_r.param, got_r.status, got_r.handle, got_r.target,
                       got_r.message, got_r.param);
          end
        end
      end
      if (in_valid && in_ready)
        run_timer_item(in_kind, in_target, in_message_code, in_param_value,
                       in_interval, in_handle);
    end
  end

endmodule

### bench/sorted_timer_queue_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_core_test
// drives directed and random tick, schedule, poll and cancel beats through the
// timer queue under random idling and long result stalls, switches interval
// scaling between phases, and reports the checker's verdict
// ----------------------------------------------------------------------------
module sorted_timer_queue_core_test;
  import stq_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [31:0] in_target = '0;
  logic signed [31:0] in_message_code = '0;
  logic signed [31:0] in_param_value = '0;
  logic [IVL_W-1:0] in_interval = '0;
  logic [4:0] in_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [4:0] out_handle_out;
  logic [31:0] out_fired_target;
  logic signed [31:0] out_fired_message;
  logic signed [31:0] out_fired_param;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int  fail_count;
  int  pending;
  int  idle_cycles;
  bit  no_gaps;
  bit  long_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_timer_queue_core dut (.*);

  sorted_timer_queue_core_checker chk (.*);

  // watchdog on cycles with no beat of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** sorted_timer_queue_core: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(kind_t kind, logic [31:0] tgt, logic [31:0] msg,
      logic [31:0] prm, logic [IVL_W-1:0] ivl, logic [4:0] h);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = kind;
    in_target = tgt;
    in_message_code = msg;
    in_param_value = prm;
    in_interval = ivl;
    in_handle = h;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_scale(logic on);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 2'(4 * REG_HUNDRED_US);
    pwdata = {31'b0, on};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [IVL_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return IVL_W'($urandom_range(0, 15));
    if (r < 90) return IVL_W'($urandom_range(0, 1000));
    return IVL_W'($urandom_range(0, 429496729));
  endfunction

  // weights in percent: tick, schedule, poll, rest cancel
  task automatic random_phase(int count, int w_tick, int w_sched, int w_poll);
    int r;
    kind_t k;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) no_gaps = ~no_gaps;
      if (n == count / 2 && count > 400) long_hold = 1'b1;
      r = $urandom_range(0, 99);
      if (r < w_tick) k = KIND_TICK;
      else if (r < w_tick + w_sched) k = KIND_SCHEDULE;
      else if (r < w_tick + w_sched + w_poll) k = KIND_POLL;
      else k = KIND_CANCEL;
      send_beat(k, $urandom, $urandom, $urandom, pick_interval(),
                5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // directed: empty poll, inactive cancel, extremes, zero interval firing
    send_beat(KIND_POLL, '0, '0, '0, '0, '0);
    send_beat(KIND_CANCEL, '0, '0, '0, '0, 5'd31);
    send_beat(KIND_SCHEDULE, '1, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send_beat(KIND_POLL, '0, '0, '0, '0, '0);
    send_beat(KIND_TICK, '0, '0, '0, '0, '0);
    send_beat(KIND_POLL, '0, '0, '0, '0, '0);
    send_beat(KIND_SCHEDULE, '0, 32'h7fff_ffff, 32'h8000_0000, 29'd429496729, '1);
    send_beat(KIND_SCHEDULE, 32'h5a5a_a5a5, '1, '0, 29'd3, '0);
    send_beat(KIND_SCHEDULE, 32'h1234_5678, '0, '1, 29'd1, '0);
    send_beat(KIND_POLL, '0, '0, '0, '0, '0);
    send_beat(KIND_CANCEL, '0, '0, '0, '0, 5'd1);
    send_beat(KIND_CANCEL, '0, '0, '0, '0, 5'd1);
    for (int i = 0; i < 12; i++) send_beat(KIND_TICK, '0, '0, '0, '0, '0);
    send_beat(KIND_POLL, '0, '0, '0, '0, '0);
    write_scale(1'b0);
    send_beat(KIND_SCHEDULE, '1, '1, '1, '0, '0);
    // fill the pool until schedules are refused
    random_phase(200, 5, 80, 5);
    random_phase(700, 40, 25, 25);
    write_scale(1'b1);
    random_phase(500, 45, 25, 22);
    write_scale(1'b0);
    random_phase(600, 30, 35, 25);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("** sorted_timer_queue_core: PASSED **");
    else
      $display("** sorted_timer_queue_core: FAILED **");
    $finish;
  end

endmodule
